### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define CHK_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, off while reset is held.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

### hw/rtl/fta_pkg.sv
package fta_pkg;

    localparam int VALUE_BITS  = 12;
    localparam int DEGREE_BITS = 16;

    localparam int DEG_W      = DEGREE_BITS + 1;
    localparam int FUZZ_SETS  = 7;
    localparam int CFG_REGS   = 7;
    localparam int CFG_W      = 4 * VALUE_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int SUM_W      = DEG_W + 2;
    localparam int WGT_W      = DEG_W + 8;
    localparam int FRAC_SHIFT = 8;
    localparam int ASSESS_W   = 14;
    localparam int STRENGTH_W = 17;

    localparam logic [DEG_W-1:0] DEG_ONE = {1'b1, {DEGREE_BITS{1'b0}}};

    // register indexes, also the fuzzy set lanes
    localparam int CFG_TINY     = 0;
    localparam int CFG_SMALL    = 1;
    localparam int CFG_MODERATE = 2;
    localparam int CFG_LARGE    = 3;
    localparam int CFG_CLOSE    = 4;
    localparam int CFG_MEDIUM   = 5;
    localparam int CFG_FAR      = 6;

    localparam logic [5:0] W_LOW  = 6'd10;
    localparam logic [5:0] W_MID  = 6'd30;
    localparam logic [5:0] W_HIGH = 6'd50;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [DEG_W-1:0]      t_deg;
    typedef logic [CFG_W-1:0]      t_cfg;

    typedef struct packed {
        t_value num;
        t_value den;
    } t_ratio;

    typedef struct packed {
        t_deg lo;
        t_deg mi;
        t_deg hi;
    } t_strengths;

    typedef struct packed {
        t_value force_value;
        t_value distance_value;
    } t_in_word;

    typedef struct packed {
        logic [ASSESS_W-1:0]   assessment;
        logic [STRENGTH_W-1:0] low_strength;
        logic [STRENGTH_W-1:0] medium_strength;
        logic [STRENGTH_W-1:0] high_strength;
        logic                  no_rule_fired;
    } t_out_word;

endpackage

### hw/rtl/fta_fuzzify.sv
module fta_fuzzify (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  fta_pkg::t_in_word i_in,
    input  fta_pkg::t_cfg     i_cfg [fta_pkg::CFG_REGS],
    output logic              o_valid,
    output fta_pkg::t_ratio   o_ratio [fta_pkg::FUZZ_SETS]
);
    import fta_pkg::*;

    localparam t_ratio R_ZERO = '{num: t_value'(0), den: t_value'(1)};
    localparam t_ratio R_ONE  = '{num: t_value'(1), den: t_value'(1)};

    logic   r_valid;
    t_ratio r_ratio [FUZZ_SETS];
    t_ratio n_ratio [FUZZ_SETS];

    function automatic t_value bp(input t_cfg c, input int i);
        return c[i*VALUE_BITS +: VALUE_BITS];
    endfunction

    function automatic t_ratio tri_r(input t_value v, input t_cfg c);
        t_value x0, x1, x2;
        t_ratio r;
        x0 = bp(c, 0);
        x1 = bp(c, 1);
        x2 = bp(c, 2);
        if (v <= x0 || v >= x2) begin
            r = R_ZERO;
        end else if (v == x1) begin
            r = R_ONE;
        end else if (v < x1) begin
            r = '{num: v - x0, den: x1 - x0};
        end else begin
            r = '{num: x2 - v, den: x2 - x1};
        end
        return r;
    endfunction

    function automatic t_ratio trap_r(input t_value v, input t_cfg c);
        t_value x0, x1, x2, x3;
        t_ratio r;
        x0 = bp(c, 0);
        x1 = bp(c, 1);
        x2 = bp(c, 2);
        x3 = bp(c, 3);
        if (v <= x0 || v >= x3) begin
            r = R_ZERO;
        end else if (v >= x1 && v <= x2) begin
            r = R_ONE;
        end else if (v < x1) begin
            r = '{num: v - x0, den: x1 - x0};
        end else begin
            r = '{num: x3 - v, den: x3 - x2};
        end
        return r;
    endfunction

    function automatic t_ratio grade_r(input t_value v, input t_cfg c);
        t_value x0, x1;
        t_ratio r;
        x0 = bp(c, 0);
        x1 = bp(c, 1);
        if (v < x0) begin
            r = R_ZERO;
        end else if (v > x1 || x1 == x0) begin
            r = R_ONE;
        end else begin
            r = '{num: v - x0, den: x1 - x0};
        end
        return r;
    endfunction

    always_comb begin
        n_ratio[CFG_TINY]     = tri_r(i_in.force_value, i_cfg[CFG_TINY]);
        n_ratio[CFG_SMALL]    = trap_r(i_in.force_value, i_cfg[CFG_SMALL]);
        n_ratio[CFG_MODERATE] = trap_r(i_in.force_value, i_cfg[CFG_MODERATE]);
        n_ratio[CFG_LARGE]    = grade_r(i_in.force_value, i_cfg[CFG_LARGE]);
        n_ratio[CFG_CLOSE]    = tri_r(i_in.distance_value, i_cfg[CFG_CLOSE]);
        n_ratio[CFG_MEDIUM]   = trap_r(i_in.distance_value, i_cfg[CFG_MEDIUM]);
        n_ratio[CFG_FAR]      = grade_r(i_in.distance_value, i_cfg[CFG_FAR]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ratio <= n_ratio;
        end
    end

    assign o_valid = r_valid;
    assign o_ratio = r_ratio;

endmodule

### hw/rtl/fta_memb_div.sv
module fta_memb_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  fta_pkg::t_ratio i_ratio [fta_pkg::FUZZ_SETS],
    output logic            o_valid,
    output fta_pkg::t_deg   o_deg [fta_pkg::FUZZ_SETS]
);
    import fta_pkg::*;

    localparam int NSTG  = DEG_W;
    localparam int REM_W = VALUE_BITS + 1;

    logic               r_v   [NSTG];
    logic [REM_W-1:0]   r_rem [NSTG][FUZZ_SETS];
    t_value             r_den [NSTG][FUZZ_SETS];
    t_deg               r_q   [NSTG][FUZZ_SETS];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic             w_v;
        logic [REM_W-1:0] w_rem [FUZZ_SETS];
        t_value           w_den [FUZZ_SETS];
        t_deg             w_q   [FUZZ_SETS];

        if (s == 0) begin : g_first
            assign w_v = i_valid;
            for (genvar l = 0; l < FUZZ_SETS; l++) begin : g_ln
                assign w_rem[l] = {1'b0, i_ratio[l].num};
                assign w_den[l] = i_ratio[l].den;
                assign w_q[l]   = '0;
            end
        end else begin : g_next
            assign w_v   = r_v[s-1];
            assign w_rem = r_rem[s-1];
            assign w_den = r_den[s-1];
            assign w_q   = r_q[s-1];
        end

        for (genvar l = 0; l < FUZZ_SETS; l++) begin : g_lane
            logic             w_ge;
            logic [REM_W-1:0] w_sub;
            assign w_ge  = w_rem[l] >= {1'b0, w_den[l]};
            assign w_sub = w_ge ? w_rem[l] - {1'b0, w_den[l]} : w_rem[l];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s][l] <= {w_sub[VALUE_BITS-1:0], 1'b0};
                    r_den[s][l] <= w_den[l];
                    r_q[s][l]   <= {w_q[l][DEG_W-2:0], w_ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v;
            end
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_deg   = r_q[NSTG-1];

endmodule

### hw/rtl/fta_rules.sv
module fta_rules (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  fta_pkg::t_deg               i_deg [fta_pkg::FUZZ_SETS],
    output logic                        o_valid,
    output fta_pkg::t_strengths         o_str,
    output logic [fta_pkg::WGT_W-1:0]   o_wgt,
    output logic [fta_pkg::SUM_W-1:0]   o_sum
);
    import fta_pkg::*;

    logic             r_v1;
    logic             r_v2;
    t_strengths       r_s1;
    t_strengths       r_s2;
    t_strengths       n_s1;
    logic [WGT_W-1:0] r_wgt;
    logic [SUM_W-1:0] r_sum;

    function automatic t_deg fmin(input t_deg a, input t_deg b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_deg fmax(input t_deg a, input t_deg b);
        return (a > b) ? a : b;
    endfunction

    always_comb begin
        n_s1.lo = fmax(fmax(fmin(i_deg[CFG_MEDIUM], i_deg[CFG_TINY]),
                            fmin(i_deg[CFG_MEDIUM], i_deg[CFG_SMALL])),
                       fmin(i_deg[CFG_FAR], DEG_ONE - i_deg[CFG_LARGE]));
        n_s1.mi = fmax(fmax(fmin(i_deg[CFG_CLOSE], i_deg[CFG_TINY]),
                            fmin(i_deg[CFG_MEDIUM], i_deg[CFG_MODERATE])),
                       fmin(i_deg[CFG_FAR], i_deg[CFG_LARGE]));
        n_s1.hi = fmax(fmin(i_deg[CFG_CLOSE], DEG_ONE - i_deg[CFG_TINY]),
                       fmin(i_deg[CFG_MEDIUM], i_deg[CFG_LARGE]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1  <= n_s1;
            r_s2  <= r_s1;
            r_wgt <= WGT_W'(r_s1.lo) * WGT_W'(W_LOW)
                   + WGT_W'(r_s1.mi) * WGT_W'(W_MID)
                   + WGT_W'(r_s1.hi) * WGT_W'(W_HIGH);
            r_sum <= SUM_W'(r_s1.lo) + SUM_W'(r_s1.mi) + SUM_W'(r_s1.hi);
        end
    end

    assign o_valid = r_v2;
    assign o_str   = r_s2;
    assign o_wgt   = r_wgt;
    assign o_sum   = r_sum;

endmodule

### hw/rtl/fta_defuzz.sv
module fta_defuzz (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  fta_pkg::t_strengths       i_str,
    input  logic [fta_pkg::WGT_W-1:0] i_wgt,
    input  logic [fta_pkg::SUM_W-1:0] i_sum,
    output logic                      o_valid,
    output fta_pkg::t_out_word        o_word
);
    import fta_pkg::*;

    localparam int NSTG  = ASSESS_W;
    localparam int DVD_W = WGT_W + FRAC_SHIFT;

    logic [DVD_W-1:0] w_dvd;

    logic                r_v    [NSTG];
    logic [SUM_W-1:0]    r_rem  [NSTG];
    logic [SUM_W-1:0]    r_sum  [NSTG];
    logic [ASSESS_W-1:0] r_dl   [NSTG];
    logic [ASSESS_W-1:0] r_q    [NSTG];
    t_strengths          r_str  [NSTG];
    logic                r_none [NSTG];

    assign w_dvd = {i_wgt, FRAC_SHIFT'(0)};

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic                w_v;
        logic [SUM_W-1:0]    w_rem;
        logic [SUM_W-1:0]    w_sum;
        logic [ASSESS_W-1:0] w_dl;
        logic [ASSESS_W-1:0] w_q;
        t_strengths          w_str;
        logic                w_none;
        logic [SUM_W:0]      w_ext;
        logic                w_ge;
        logic [SUM_W:0]      w_sub;

        if (s == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = w_dvd[ASSESS_W +: SUM_W];
            assign w_sum  = i_sum;
            assign w_dl   = w_dvd[ASSESS_W-1:0];
            assign w_q    = '0;
            assign w_str  = i_str;
            assign w_none = (i_sum == '0);
        end else begin : g_next
            assign w_v    = r_v[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_sum  = r_sum[s-1];
            assign w_dl   = r_dl[s-1];
            assign w_q    = r_q[s-1];
            assign w_str  = r_str[s-1];
            assign w_none = r_none[s-1];
        end

        assign w_ext = {w_rem, w_dl[ASSESS_W-1]};
        assign w_ge  = w_ext >= {1'b0, w_sum};
        assign w_sub = w_ge ? w_ext - {1'b0, w_sum} : w_ext;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_sub[SUM_W-1:0];
                r_sum[s]  <= w_sum;
                r_dl[s]   <= {w_dl[ASSESS_W-2:0], 1'b0};
                r_q[s]    <= {w_q[ASSESS_W-2:0], w_ge};
                r_str[s]  <= w_str;
                r_none[s] <= w_none;
            end
        end
    end

    always_comb begin
        o_word.assessment      = r_none[NSTG-1] ? '0 : r_q[NSTG-1];
        o_word.low_strength    = STRENGTH_W'(r_str[NSTG-1].lo);
        o_word.medium_strength = STRENGTH_W'(r_str[NSTG-1].mi);
        o_word.high_strength   = STRENGTH_W'(r_str[NSTG-1].hi);
        o_word.no_rule_fired   = r_none[NSTG-1];
    end

    assign o_valid = r_v[NSTG-1];

endmodule

### hw/rtl/fuzzy_threat_assessment_unit.sv
// Channel   Handshake            Word
// in        i_valid / o_ready    force_value, distance_value
// out       o_valid / i_ready    assessment, three strengths, no_rule_fired
// cfg       i_cfg_we             i_cfg_idx selects, i_cfg_data written
//
// One word in and one word out per cycle while the output is not held; the pipeline
// is one fuzzify stage, 17 stages of the membership dividers, two rule stages, 14
// stages of the assessment divider and the output register.
// Reset clears all valid bits and the breakpoint registers.
// A held output word stalls the whole pipeline; nothing is dropped or repeated.
module fuzzy_threat_assessment_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  fta_pkg::t_in_word             i_in_word,
    output logic                          o_valid,
    input  logic                          i_ready,
    output fta_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_we,
    input  logic [fta_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fta_pkg::CFG_W-1:0]     i_cfg_data
);
    import fta_pkg::*;

    logic       w_adv;
    t_cfg       r_cfg [CFG_REGS];
    logic       w_fz_v;
    t_ratio     w_ratio [FUZZ_SETS];
    logic       w_md_v;
    t_deg       w_deg [FUZZ_SETS];
    logic       w_ru_v;
    t_strengths w_str;
    logic [WGT_W-1:0] w_wgt;
    logic [SUM_W-1:0] w_sum;
    logic       w_df_v;
    t_out_word  w_word;
    logic       r_out_v;
    t_out_word  r_out;

    assign w_adv   = !r_out_v || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_we && i_cfg_idx < CFG_IDX_W'(CFG_REGS)) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    fta_fuzzify u_fuzz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_valid),
        .i_in    (i_in_word),
        .i_cfg   (r_cfg),
        .o_valid (w_fz_v),
        .o_ratio (w_ratio)
    );

    fta_memb_div u_mdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_fz_v),
        .i_ratio (w_ratio),
        .o_valid (w_md_v),
        .o_deg   (w_deg)
    );

    fta_rules u_rules (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_md_v),
        .i_deg   (w_deg),
        .o_valid (w_ru_v),
        .o_str   (w_str),
        .o_wgt   (w_wgt),
        .o_sum   (w_sum)
    );

    fta_defuzz u_defz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_ru_v),
        .i_str   (w_str),
        .i_wgt   (w_wgt),
        .i_sum   (w_sum),
        .o_valid (w_df_v),
        .o_word  (w_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= w_df_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_word;
        end
    end

    assign o_valid    = r_out_v;
    assign o_out_word = r_out;

endmodule

### hw/rtl/fta_checker.sv
`include "assert_macros.svh"

module fta_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_ready,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  fta_pkg::t_out_word            o_out_word
);
    import fta_pkg::*;

    `CHK_NEXT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n, !o_valid)

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_word))

    `CHK_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready)

    `CHK_IMPLY(a_none_zero, i_clk, i_rst_n, o_valid && o_out_word.no_rule_fired, o_out_word.assessment == '0 && o_out_word.low_strength == '0 && o_out_word.high_strength == '0)

    `CHK_IMPLY(a_assess_range, i_clk, i_rst_n, o_valid && !o_out_word.no_rule_fired, o_out_word.assessment >= ASSESS_W'(2560) && o_out_word.assessment <= ASSESS_W'(12800))

endmodule

bind fuzzy_threat_assessment_unit fta_checker u_fta_checker (.*);
